// File: hw/rtl/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
package sitda_pkg;

   localparam int unsigned VALUE_WIDTH = 32;
   localparam int unsigned CHAR_WIDTH  = 6;
   localparam int unsigned NUM_DIGITS  = 10;
   localparam int unsigned BCD_WIDTH   = 4 * NUM_DIGITS;
   localparam int unsigned BITS_PER_STEP = 2;
   localparam int unsigned NUM_STEPS   = VALUE_WIDTH / BITS_PER_STEP;
   localparam int unsigned STEP_CNT_WIDTH  = $clog2(NUM_STEPS);
   localparam int unsigned DIGIT_IDX_WIDTH = $clog2(NUM_DIGITS);

   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 6'd57;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic trim;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic step_last;
      logic negative;
      logic digit_last;
      logic out_free;
   } status_type;

endpackage

// File: hw/rtl/sitda_ctrl.sv
// Sequencing state machine for the converter: load, convert, trim, emit.
module sitda_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sitda_pkg::status_type status,
   output sitda_pkg::cmd_type    cmd
);

   sitda_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sitda_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sitda_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sitda_pkg::ST_CONVERT;
            end
         end
         sitda_pkg::ST_CONVERT: begin
            if (status.step_last) begin
               state_in = sitda_pkg::ST_TRIM;
            end
         end
         sitda_pkg::ST_TRIM: begin
            state_in = status.negative ? sitda_pkg::ST_SIGN : sitda_pkg::ST_DIGITS;
         end
         sitda_pkg::ST_SIGN: begin
            if (status.out_free) begin
               state_in = sitda_pkg::ST_DIGITS;
            end
         end
         sitda_pkg::ST_DIGITS: begin
            if (status.out_free && status.digit_last) begin
               state_in = sitda_pkg::ST_IDLE;
            end
         end
         default: state_in = sitda_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         sitda_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         sitda_pkg::ST_CONVERT: cmd.step = 1'b1;
         sitda_pkg::ST_TRIM:    cmd.trim = 1'b1;
         sitda_pkg::ST_SIGN:    cmd.emit_sign = status.out_free;
         sitda_pkg::ST_DIGITS:  cmd.emit_digit = status.out_free;
         default: begin
            cmd       = '0;
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// File: hw/rtl/sitda_datapath.sv
// Magnitude register, shift-and-add-3 BCD converter, digit selector and output register.
module sitda_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] req_value,
   input  sitda_pkg::cmd_type                      cmd,
   output sitda_pkg::status_type                   status,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [sitda_pkg::CHAR_WIDTH-1:0]       rsp_character,
   output logic                                   rsp_last
);

   logic [sitda_pkg::VALUE_WIDTH-1:0]     mag_ff, mag_in;
   logic [sitda_pkg::BCD_WIDTH-1:0]       bcd_ff, bcd_in;
   logic                                  neg_ff, neg_in;
   logic [sitda_pkg::STEP_CNT_WIDTH-1:0]  step_cnt_ff, step_cnt_in;
   logic [sitda_pkg::DIGIT_IDX_WIDTH-1:0] idx_ff, idx_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [sitda_pkg::CHAR_WIDTH-1:0]      rsp_character_ff, rsp_character_in;
   logic                                  rsp_last_ff, rsp_last_in;

   logic [sitda_pkg::BCD_WIDTH-1:0]       bcd_step;
   logic [sitda_pkg::VALUE_WIDTH-1:0]     mag_step;
   logic [sitda_pkg::DIGIT_IDX_WIDTH-1:0] msd_idx;
   logic [3:0]                            cur_digit;

   // Two shift-and-add-3 iterations per step: every digit of five or more gets
   // three added before the next magnitude bit shifts in.
   always_comb begin
      bcd_step = bcd_ff;
      mag_step = mag_ff;
      for (int b = 0; b < sitda_pkg::BITS_PER_STEP; b++) begin
         for (int d = 0; d < sitda_pkg::NUM_DIGITS; d++) begin
            if (bcd_step[4*d +: 4] >= 4'd5) begin
               bcd_step[4*d +: 4] = bcd_step[4*d +: 4] + 4'd3;
            end
         end
         bcd_step = {bcd_step[sitda_pkg::BCD_WIDTH-2:0], mag_step[sitda_pkg::VALUE_WIDTH-1]};
         mag_step = {mag_step[sitda_pkg::VALUE_WIDTH-2:0], 1'b0};
      end
   end

   // Position of the most significant nonzero digit; zero keeps position zero.
   always_comb begin
      msd_idx = '0;
      for (int d = 0; d < sitda_pkg::NUM_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] != 4'd0) begin
            msd_idx = sitda_pkg::DIGIT_IDX_WIDTH'(d);
         end
      end
   end

   assign cur_digit = bcd_ff[4*idx_ff +: 4];

   always_comb begin
      mag_in      = mag_ff;
      bcd_in      = bcd_ff;
      neg_in      = neg_ff;
      step_cnt_in = step_cnt_ff;
      idx_in      = idx_ff;
      if (cmd.load) begin
         neg_in      = req_value[sitda_pkg::VALUE_WIDTH-1];
         // Negating as unsigned keeps the most negative value exact.
         mag_in      = neg_in ? (~req_value + 1'b1) : req_value;
         bcd_in      = '0;
         step_cnt_in = '0;
      end else if (cmd.step) begin
         mag_in      = mag_step;
         bcd_in      = bcd_step;
         step_cnt_in = step_cnt_ff + 1'b1;
      end else if (cmd.trim) begin
         idx_in      = msd_idx;
      end else if (cmd.emit_digit) begin
         idx_in      = idx_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      if (cmd.emit_sign) begin
         rsp_valid_in     = 1'b1;
         rsp_character_in = sitda_pkg::CHAR_MINUS;
         rsp_last_in      = 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_valid_in     = 1'b1;
         rsp_character_in = sitda_pkg::CHAR_ZERO + {2'b00, cur_digit};
         rsp_last_in      = (idx_ff == '0);
      end else if (!rsp_stall) begin
         rsp_valid_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_cnt_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         step_cnt_ff  <= step_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff           <= mag_in;
      bcd_ff           <= bcd_in;
      neg_ff           <= neg_in;
      idx_ff           <= idx_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign status.step_last  = (step_cnt_ff == sitda_pkg::STEP_CNT_WIDTH'(sitda_pkg::NUM_STEPS - 1));
   assign status.negative   = neg_ff;
   assign status.digit_last = (idx_ff == '0);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// File: hw/rtl/signed_int_to_decimal_ascii_core.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
//
// The request channel (req_valid, req_stall, req_value) takes one signed
// 32-bit integer per transfer. The response channel (rsp_valid, rsp_stall,
// rsp_character, rsp_last) returns its decimal text one ASCII character per
// transfer, most significant first, with a leading minus sign for negative
// values and rsp_last set on the final digit. Zero comes out as one '0'.
//
// After a request transfer the magnitude runs through a shift-and-add-3 binary
// to BCD converter that takes two bits per cycle, and a trim state then finds
// the leading digit. The first character is then registered and can be taken
// at the next edge. Characters follow one per cycle while the receiver
// does not stall; a stall holds the current character and pauses the
// sequencer. req_stall is low again once the last character sits in the
// output register, so the next conversion overlaps it.
//
// Reset (synchronous, active high) returns the sequencer to idle and drops
// rsp_valid; any conversion in progress is abandoned.
module signed_int_to_decimal_ascii_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [sitda_pkg::CHAR_WIDTH-1:0]       rsp_character,
   output logic                                   rsp_last
);

   sitda_pkg::cmd_type    cmd;
   sitda_pkg::status_type status;

   sitda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sitda_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

// File: hw/rtl/sitda_checker.sv
// Port-level checks for the converter and the bind that attaches them.
module sitda_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic signed [sitda_pkg::VALUE_WIDTH-1:0] req_value,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic [sitda_pkg::CHAR_WIDTH-1:0]       rsp_character,
   input logic                                   rsp_last
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("stalled response changed");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == sitda_pkg::CHAR_MINUS) ||
                    (rsp_character >= sitda_pkg::CHAR_ZERO && rsp_character <= sitda_pkg::CHAR_NINE))
      else $error("response character is neither a sign nor a digit");

   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_character == sitda_pkg::CHAR_MINUS) |-> !rsp_last)
      else $error("minus sign marked as last character");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a conversion is starting");

endmodule

bind signed_int_to_decimal_ascii_core sitda_checker u_sitda_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_value     (req_value),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last)
);

// File: bench/sitda_text_checker.sv
// Checker that predicts and compares the decimal text for every accepted integer.
`timescale 1ns / 100ps

module sitda_text_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_stall,
   input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] req_value,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   input  logic [sitda_pkg::CHAR_WIDTH-1:0]         rsp_character,
   input  logic                                     rsp_last,
   output int                                       fault_count,
   output int                                       chars_pending
);

   localparam int unsigned RADIX      = 10;
   localparam int          SHOW_LIMIT = 10;

   typedef struct packed {
      logic [sitda_pkg::CHAR_WIDTH-1:0] character;
      logic                             last;
   } text_char_type;

   text_char_type text_due[$];
   int            faults = 0;
   int            pending = 0;

   assign fault_count   = faults;
   assign chars_pending = pending;

   // Queues the characters of one integer, sign first, most significant digit next.
   function automatic void spell_decimal(input logic [sitda_pkg::VALUE_WIDTH-1:0] value);
      logic [sitda_pkg::VALUE_WIDTH-1:0] magnitude;
      logic [3:0]                        digit_stack[sitda_pkg::NUM_DIGITS];
      int                                n_digits;
      text_char_type                     glyph;
      // Negating in unsigned arithmetic keeps the most negative value exact.
      magnitude = value[sitda_pkg::VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      n_digits  = 0;
      do begin
         digit_stack[n_digits] = 4'(magnitude % RADIX);
         magnitude = magnitude / RADIX;
         n_digits++;
      end while (magnitude != 0 && n_digits < sitda_pkg::NUM_DIGITS);
      if (value[sitda_pkg::VALUE_WIDTH-1]) begin
         glyph.character = sitda_pkg::CHAR_MINUS;
         glyph.last      = 1'b0;
         text_due.push_back(glyph);
      end
      for (int k = n_digits - 1; k >= 0; k--) begin
         glyph.character = sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_WIDTH'(digit_stack[k]);
         glyph.last      = (k == 0);
         text_due.push_back(glyph);
      end
   endfunction

   always @(posedge clock) begin : watch
      text_char_type want;
      if (reset) begin
         text_due.delete();
      end else begin
         // Compare before queuing new text so a fresh request never matches an old transfer.
         if (rsp_valid && !rsp_stall) begin
            if (text_due.size() == 0) begin
               faults++;
               if (faults <= SHOW_LIMIT)
                  $display("%0t: unexpected character %0d last %0b", $realtime,
                           rsp_character, rsp_last);
            end else begin
               want = text_due.pop_front();
               if (want.character !== rsp_character || want.last !== rsp_last) begin
                  faults++;
                  if (faults <= SHOW_LIMIT)
                     $display("%0t: character %0d last %0b, expected %0d last %0b",
                              $realtime, rsp_character, rsp_last, want.character,
                              want.last);
               end
            end
         end
         if (req_valid && !req_stall)
            spell_decimal(req_value);
      end
      pending = text_due.size();
   end

endmodule

// File: bench/signed_int_to_decimal_ascii_core_test.sv
// Top of the testbench: clock, reset, integer stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_core_test;

   localparam int PHASE_ITEMS = 44;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_WAIT  = 40;

   logic                                     clock = 1'b0;
   logic                                     reset = 1'b1;
   logic                                     req_valid = 1'b0;
   logic                                     req_stall;
   logic signed [sitda_pkg::VALUE_WIDTH-1:0] req_value = '0;
   logic                                     rsp_valid;
   logic                                     rsp_stall = 1'b0;
   logic [sitda_pkg::CHAR_WIDTH-1:0]         rsp_character;
   logic                                     rsp_last;
   int                                       fault_count;
   int                                       chars_pending;

   int unsigned send_gap_pct = 38;
   int unsigned take_gap_pct = 69;
   bit          hold_wanted  = 1'b0;

   logic [sitda_pkg::VALUE_WIDTH-1:0] corner_values[$] = '{
      32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'd999999999, 32'd1000000000, -32'sd1000000000, 32'd1234567890,
      -32'sd1234567890, 32'h7FFF_FFFF, -32'sd2147483647, 32'h8000_0000,
      32'd505050505, 32'hAAAA_AAAA, 32'h5555_5555
   };

   always #1 clock = ~clock;

   signed_int_to_decimal_ascii_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   sitda_text_checker u_text_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .fault_count   (fault_count),
      .chars_pending (chars_pending)
   );

   // Mixes full-range words, short numbers, values next to powers of ten and shifted words, each negated at random.
   function automatic logic [sitda_pkg::VALUE_WIDTH-1:0] pick_value();
      logic [sitda_pkg::VALUE_WIDTH-1:0] v;
      int unsigned                       power;
      int                                k;
      power = 1;
      k     = $urandom_range(0, sitda_pkg::NUM_DIGITS - 1);
      repeat (k) power = power * 10;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = $urandom_range(0, 999);
         2: v = power - $urandom_range(0, 1);
         default: v = $urandom >> $urandom_range(0, sitda_pkg::VALUE_WIDTH - 1);
      endcase
      if ($urandom_range(0, 1))
         v = -v;
      return v;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_value(input logic [sitda_pkg::VALUE_WIDTH-1:0] v);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid = 1'b0;
         req_value = $urandom;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_value = v;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   initial begin : receiver
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_wanted && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(0, 99) < take_gap_pct);
         end
      end
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (corner_values[i])
         send_value(corner_values[i]);
      repeat (PHASE_ITEMS) send_value(pick_value());
      send_gap_pct = 69;
      take_gap_pct = 38;
      repeat (PHASE_ITEMS) send_value(pick_value());
      send_gap_pct = 0;
      take_gap_pct = 0;
      // A long receiver hold-off while requests keep coming backs the block up.
      hold_wanted = 1'b1;
      repeat (PHASE_ITEMS) send_value(pick_value());
      req_valid = 1'b0;
      while (chars_pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fault_count == 0 && chars_pending == 0)
         $display("signed_int_to_decimal_ascii_core verification clean");
      else
         $display("signed_int_to_decimal_ascii_core verification failed");
      $finish;
   end

   initial begin : watchdog
      #1000000;
      $display("signed_int_to_decimal_ascii_core verification failed");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/sitda_pkg.sv
hw/rtl/sitda_ctrl.sv
hw/rtl/sitda_datapath.sv
hw/rtl/signed_int_to_decimal_ascii_core.sv
hw/rtl/sitda_checker.sv
bench/sitda_text_checker.sv
bench/signed_int_to_decimal_ascii_core_test.sv
